FILE: design/erf_pkg.sv
// ---------------------------------------------------------------------------
// erf_pkg
// Shared types, constants and saturation helpers of the ring field core.
// ---------------------------------------------------------------------------
package erf_pkg;

   localparam int RING_COUNT_DEF = 64;

   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_SPAWN  = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_KICK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_SPAWN_RADIUS = 3'd0;
   localparam logic [2:0] REG_LIFE_BASE    = 3'd1;
   localparam logic [2:0] REG_LIFE_PER_STR = 3'd2;
   localparam logic [2:0] REG_CENTER_X     = 3'd3;
   localparam logic [2:0] REG_CENTER_Y     = 3'd4;
   localparam logic [2:0] REG_PUSH_GAIN    = 3'd5;
   localparam logic [2:0] REG_BAND_WIDTH   = 3'd6;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // input tdata: strength, speed, time_step, pos_x, pos_y, one pad bit
   localparam int REQ_DW = 160;

   typedef struct packed {
      logic [30:0]        spawn_radius;
      logic [30:0]        life_base;
      logic [30:0]        life_per_strength;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] push_gain;
      logic [30:0]        band_width;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] lifetime;
      logic signed [31:0] age;
      logic signed [31:0] strength;
      logic signed [31:0] speed;
      logic signed [31:0] radius;
   } ring_entry_type;

   localparam int ENTRY_W = $bits(ring_entry_type);

   function automatic logic signed [31:0] sat_to32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) r = Q_MAX;
      else if (v < -35'sd2147483648) r = Q_MIN;
      else r = v[31:0];
      return r;
   endfunction

   // Q16.16 product: floor shift by 16, then saturate
   function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
      logic signed [63:0] s;
      logic signed [31:0] r;
      s = p >>> 16;
      if (s > 64'sd2147483647) r = Q_MAX;
      else if (s < -64'sd2147483648) r = Q_MIN;
      else r = s[31:0];
      return r;
   endfunction

endpackage

FILE: design/erf_ram.sv
// ---------------------------------------------------------------------------
// erf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module erf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/erf_sqrt.sv
// ---------------------------------------------------------------------------
// erf_sqrt
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module erf_sqrt
   import erf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   localparam logic [5:0] STEPS = 6'd32;

   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rad_ff, rad_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic        done_ff, done_in;
   logic [34:0] rem_sh;
   logic [34:0] trial;

   always_comb begin
      rem_sh  = {rem_ff[32:0], rad_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = STEPS;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 6'd1;
         rad_in  = {rad_ff[61:0], 2'b00};
         done_in = (cnt_ff == 6'd1);
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: design/erf_div.sv
// ---------------------------------------------------------------------------
// erf_div
// Two-lane restoring divider, shared divisor, truncating signed quotient.
// Quotient magnitude must fit 32 bits (|num| < den * 2^32).
// ---------------------------------------------------------------------------
module erf_div
   import erf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num_x,
   input  logic signed [63:0] num_y,
   input  logic [32:0]        den,
   output logic               done,
   output logic signed [31:0] quo_x,
   output logic signed [31:0] quo_y
);

   localparam int         LANES = 2;
   localparam logic [5:0] STEPS = 6'd32;

   logic [5:0]              cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [32:0]             den_ff, den_in;
   logic [LANES-1:0]        neg_ff, neg_in;
   logic [LANES-1:0][32:0]  rem_ff, rem_in;
   logic [LANES-1:0][31:0]  sh_ff, sh_in;
   logic [LANES-1:0][31:0]  q_ff, q_in;
   logic [LANES-1:0][63:0]  num;
   logic [LANES-1:0][63:0]  mag;
   logic [LANES-1:0][33:0]  rem_sh;
   logic [LANES-1:0][31:0]  quo;

   always_comb begin
      num[0]  = num_x;
      num[1]  = num_y;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      den_in  = den_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      if (start) begin
         cnt_in = STEPS;
         den_in = den;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
      for (int l = 0; l < LANES; l++) begin
         mag[l]    = num[l][63] ? (64'd0 - num[l]) : num[l];
         rem_sh[l] = {rem_ff[l], sh_ff[l][31]};
         quo[l]    = neg_ff[l] ? (32'd0 - q_ff[l]) : q_ff[l];
         if (start) begin
            neg_in[l] = num[l][63];
            rem_in[l] = {1'b0, mag[l][63:32]};
            sh_in[l]  = mag[l][31:0];
            q_in[l]   = '0;
         end else if (cnt_ff != '0) begin
            sh_in[l] = {sh_ff[l][30:0], 1'b0};
            if (rem_sh[l] >= {1'b0, den_ff}) begin
               rem_in[l] = 33'(rem_sh[l] - {1'b0, den_ff});
               q_in[l]   = {q_ff[l][30:0], 1'b1};
            end else begin
               rem_in[l] = rem_sh[l][32:0];
               q_in[l]   = {q_ff[l][30:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
   end

   assign done  = done_ff;
   assign quo_x = quo[0];
   assign quo_y = quo[1];

endmodule

FILE: design/erf_csr.sv
// ---------------------------------------------------------------------------
// erf_csr
// APB register file holding the field's configuration.
// ---------------------------------------------------------------------------
module erf_csr
   import erf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_stb;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_idx)
            REG_SPAWN_RADIUS: cfg_in.spawn_radius      = csr_pwdata[30:0];
            REG_LIFE_BASE:    cfg_in.life_base         = csr_pwdata[30:0];
            REG_LIFE_PER_STR: cfg_in.life_per_strength = csr_pwdata[30:0];
            REG_CENTER_X:     cfg_in.center_x          = csr_pwdata;
            REG_CENTER_Y:     cfg_in.center_y          = csr_pwdata;
            REG_PUSH_GAIN:    cfg_in.push_gain         = csr_pwdata;
            REG_BAND_WIDTH:   cfg_in.band_width        = csr_pwdata[30:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SPAWN_RADIUS: csr_prdata = {1'b0, cfg_ff.spawn_radius};
         REG_LIFE_BASE:    csr_prdata = {1'b0, cfg_ff.life_base};
         REG_LIFE_PER_STR: csr_prdata = {1'b0, cfg_ff.life_per_strength};
         REG_CENTER_X:     csr_prdata = cfg_ff.center_x;
         REG_CENTER_Y:     csr_prdata = cfg_ff.center_y;
         REG_PUSH_GAIN:    csr_prdata = cfg_ff.push_gain;
         REG_BAND_WIDTH:   csr_prdata = {1'b0, cfg_ff.band_width};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spawn_radius      <= 31'd393216;
         cfg_ff.life_base         <= 31'd32768;
         cfg_ff.life_per_strength <= 31'd1966;
         cfg_ff.center_x          <= '0;
         cfg_ff.center_y          <= '0;
         cfg_ff.push_gain         <= 32'sd65536;
         cfg_ff.band_width        <= 31'd1048576;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/expanding_ring_field_step_core.sv
// ---------------------------------------------------------------------------
// expanding_ring_field_step_core
// Table of expanding rings: spawn, age/grow, and push a point outward.
// ---------------------------------------------------------------------------
// Ring parameters live in one RAM of RING_COUNT entries with a single read
// port; alive bits and the live count are flip-flops, so no clearing pass is
// needed after reset. One transaction is worked at a time and gives exactly
// one result; a new one is taken while the previous result waits on rsp.
// Update sweeps the RAM one slot per cycle through a three-stage
// read/modify/write pipe. Kick finds the distance (32-step square root),
// then walks the slots, checks each live one and runs the shared 32-step
// two-lane divider for each ring that pushes. Opcode 3 answers with no
// change.
// ---------------------------------------------------------------------------
module expanding_ring_field_step_core
   import erf_pkg::*;
#(
   parameter int RING_COUNT = RING_COUNT_DEF,
   localparam int CW = $clog2(RING_COUNT + 1),
   localparam int RSP_DW = ((64 + CW + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // strength[31:0], speed[63:32], time_step[94:64], pos_x[126:95], pos_y[158:127]
   input  logic [REQ_DW-1:0] req_tdata,
   // op[1:0]
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // out_x[31:0], out_y[63:32], live_count[64+CW-1:64]
   output logic [RSP_DW-1:0] rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int AW = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(RING_COUNT - 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SPAWN_MUL, ST_SPAWN_WR, ST_UPD, ST_UPD_DRAIN,
      ST_K_SUB, ST_K_SQX, ST_K_SQY, ST_K_SQS, ST_K_ROOT,
      ST_K_RD, ST_K_CHK, ST_K_P, ST_K_MUL, ST_K_DIVS, ST_K_DIV, ST_K_ACC,
      ST_DONE
   } state_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic signed [31:0]    rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [CW-1:0]         rsp_cnt_ff, rsp_cnt_in;
   logic [AW-1:0]         wslot_ff, wslot_in;
   logic [RING_COUNT-1:0] alive_ff, alive_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  u1_vld_ff, u1_vld_in, u2_vld_ff, u2_vld_in;

   logic signed [31:0]    str_ff, str_in, spd_ff, spd_in;
   logic [30:0]           dt_ff, dt_in;
   logic signed [31:0]    px_ff, px_in, py_ff, py_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         u1_idx_ff, u1_idx_in, u2_idx_ff, u2_idx_in;
   ring_entry_type        u2_entry_ff, u2_entry_in;
   logic                  u2_dies_ff, u2_dies_in;
   logic signed [63:0]    u2_prod_ff, u2_prod_in;
   logic signed [31:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [63:0]           sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic [32:0]           dist_ff, dist_in;
   logic signed [63:0]    prod_ff, prod_in;
   logic signed [31:0]    p_ff, p_in;
   logic signed [63:0]    nx_ff, nx_in, ny_ff, ny_in;
   logic signed [31:0]    x_ff, x_in, y_ff, y_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   ring_entry_type        ram_wdata;
   ring_entry_type        rd_entry;
   logic [ENTRY_W-1:0]    rd_raw;

   logic                  sqrt_start, sqrt_done;
   logic [31:0]           sqrt_root;
   logic                  div_start, div_done;
   logic signed [31:0]    quo_x, quo_y;

   logic                  req_acc;
   logic signed [31:0]    age_new;
   logic signed [34:0]    diff;
   logic [34:0]           diff_abs;
   logic                  pushes;
   logic                  last_idx;

   erf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   erf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_COUNT)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (rd_raw)
   );

   erf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqa_ff + sqb_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   erf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num_x (nx_ff),
      .num_y (ny_ff),
      .den   (dist_ff),
      .done  (div_done),
      .quo_x (quo_x),
      .quo_y (quo_y)
   );

   assign rd_entry   = rd_raw;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign sqrt_start = (state_ff == ST_K_SQS);
   assign div_start  = (state_ff == ST_K_DIVS);
   assign last_idx   = (idx_ff == LAST_IDX);

   // update pipe stage 1: age and death test on the entry just read
   assign age_new = sat_to32(35'(rd_entry.age) + 35'($signed({1'b0, dt_ff})));

   // kick: distance band test against the ring radius
   assign diff     = $signed({2'b00, dist_ff}) - 35'(rd_entry.radius);
   assign diff_abs = diff[34] ? 35'(-diff) : 35'(diff);
   assign pushes   = alive_ff[idx_ff] && (diff_abs < {4'd0, cfg.band_width});

   always_comb begin
      state_in   = state_ff;
      rsp_vld_in = rsp_vld_ff;
      rsp_x_in   = rsp_x_ff;
      rsp_y_in   = rsp_y_ff;
      rsp_cnt_in = rsp_cnt_ff;
      wslot_in   = wslot_ff;
      alive_in   = alive_ff;
      cnt_in     = cnt_ff;
      str_in     = str_ff;
      spd_in     = spd_ff;
      dt_in      = dt_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      idx_in     = idx_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sqa_in     = sqa_ff;
      sqb_in     = sqb_ff;
      dist_in    = dist_ff;
      prod_in    = prod_ff;
      p_in       = p_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      ram_we     = 1'b0;
      ram_waddr  = u2_idx_ff;
      ram_wdata  = u2_entry_ff;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      // update pipe, runs every cycle
      u1_vld_in   = (state_ff == ST_UPD) && alive_ff[idx_ff];
      u1_idx_in   = idx_ff;
      u2_vld_in   = u1_vld_ff;
      u2_idx_in   = u1_idx_ff;
      u2_entry_in = rd_entry;
      u2_entry_in.age = age_new;
      u2_dies_in  = (age_new >= rd_entry.lifetime);
      u2_prod_in  = 64'(rd_entry.speed) * 64'($signed({1'b0, dt_ff}));

      if (u2_vld_ff) begin
         ram_we = 1'b1;
         ram_wdata.radius = sat_to32(35'(u2_entry_ff.radius) + 35'(qmul_sat(u2_prod_ff)));
         if (u2_dies_ff) begin
            alive_in[u2_idx_ff] = 1'b0;
            cnt_in = cnt_ff - CW'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               str_in = req_tdata[31:0];
               spd_in = req_tdata[63:32];
               dt_in  = req_tdata[94:64];
               px_in  = req_tdata[126:95];
               py_in  = req_tdata[158:127];
               x_in   = '0;
               y_in   = '0;
               idx_in = '0;
               unique case (req_tuser)
                  OP_SPAWN:  state_in = ST_SPAWN_MUL;
                  OP_UPDATE: state_in = ST_UPD;
                  OP_KICK:   state_in = ST_K_SUB;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_SPAWN_MUL: begin
            prod_in  = 64'(str_ff) * 64'($signed({1'b0, cfg.life_per_strength}));
            state_in = ST_SPAWN_WR;
         end
         ST_SPAWN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = wslot_ff;
            ram_wdata.radius   = $signed({1'b0, cfg.spawn_radius});
            ram_wdata.speed    = spd_ff;
            ram_wdata.strength = str_ff;
            ram_wdata.age      = '0;
            ram_wdata.lifetime = sat_to32(35'($signed({1'b0, cfg.life_base}))
                                          + 35'(qmul_sat(prod_ff)));
            if (!alive_ff[wslot_ff]) begin
               cnt_in = cnt_ff + CW'(1);
            end
            alive_in[wslot_ff] = 1'b1;
            wslot_in = (wslot_ff == LAST_IDX) ? '0 : wslot_ff + AW'(1);
            state_in = ST_DONE;
         end
         ST_UPD: begin
            if (last_idx) begin
               state_in = ST_UPD_DRAIN;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_UPD_DRAIN: begin
            if (!u1_vld_ff && !u2_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_K_SUB: begin
            x_in     = px_ff;
            y_in     = py_ff;
            dx_in    = sat_to32(35'(px_ff) - 35'(cfg.center_x));
            dy_in    = sat_to32(35'(py_ff) - 35'(cfg.center_y));
            state_in = ST_K_SQX;
         end
         ST_K_SQX: begin
            sqa_in   = 64'(dx_ff) * 64'(dx_ff);
            state_in = ST_K_SQY;
         end
         ST_K_SQY: begin
            sqb_in   = 64'(dy_ff) * 64'(dy_ff);
            state_in = ST_K_SQS;
         end
         ST_K_SQS: begin
            state_in = ST_K_ROOT;
         end
         ST_K_ROOT: begin
            if (sqrt_done) begin
               dist_in  = {1'b0, sqrt_root} + 33'd1;
               state_in = ST_K_RD;
            end
         end
         ST_K_RD: begin
            // RAM data for idx shows up next cycle; skip dead slots
            if (alive_ff[idx_ff]) begin
               state_in = ST_K_CHK;
            end else if (last_idx) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_K_CHK: begin
            prod_in = 64'(rd_entry.strength) * 64'(cfg.push_gain);
            if (pushes) begin
               state_in = ST_K_P;
            end else if (last_idx) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_K_RD;
            end
         end
         ST_K_P: begin
            p_in     = qmul_sat(prod_ff);
            state_in = ST_K_MUL;
         end
         ST_K_MUL: begin
            nx_in    = 64'(dx_ff) * 64'(p_ff);
            ny_in    = 64'(dy_ff) * 64'(p_ff);
            state_in = ST_K_DIVS;
         end
         ST_K_DIVS: begin
            state_in = ST_K_DIV;
         end
         ST_K_DIV: begin
            if (div_done) begin
               state_in = ST_K_ACC;
            end
         end
         ST_K_ACC: begin
            x_in = sat_to32(35'(x_ff) + 35'(quo_x));
            y_in = sat_to32(35'(y_ff) + 35'(quo_y));
            if (last_idx) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_K_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               rsp_x_in   = x_ff;
               rsp_y_in   = y_ff;
               rsp_cnt_in = cnt_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         rsp_x_ff   <= rsp_x_in;
         rsp_y_ff   <= rsp_y_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wslot_ff  <= '0;
         alive_ff  <= '0;
         cnt_ff    <= '0;
         u1_vld_ff <= 1'b0;
         u2_vld_ff <= 1'b0;
      end else begin
         wslot_ff  <= wslot_in;
         alive_ff  <= alive_in;
         cnt_ff    <= cnt_in;
         u1_vld_ff <= u1_vld_in;
         u2_vld_ff <= u2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      str_ff      <= str_in;
      spd_ff      <= spd_in;
      dt_ff       <= dt_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      idx_ff      <= idx_in;
      u1_idx_ff   <= u1_idx_in;
      u2_idx_ff   <= u2_idx_in;
      u2_entry_ff <= u2_entry_in;
      u2_dies_ff  <= u2_dies_in;
      u2_prod_ff  <= u2_prod_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sqa_ff      <= sqa_in;
      sqb_ff      <= sqb_in;
      dist_ff     <= dist_in;
      prod_ff     <= prod_in;
      p_ff        <= p_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DW'({rsp_cnt_ff, rsp_y_ff, rsp_x_ff});

   // live counter tracks the alive bits
   a_cnt_match: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) == $countones(alive_ff))
      else $error("live count out of step with alive bits");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("accepted transaction did not start");

   a_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == ST_K_ROOT))
      else $error("root finished outside root wait");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_K_DIV))
      else $error("divide finished outside divide wait");

   a_upd_pipe: assert property (@(posedge clock) disable iff (reset)
      (u1_vld_ff || u2_vld_ff) |-> (state_ff == ST_UPD || state_ff == ST_UPD_DRAIN))
      else $error("update pipe active outside sweep");

endmodule
